FILE: sv/cssf_pkg.sv
// ----------------------------------------------------------------------------
// cssf_pkg: shared definitions for the caseless substring finder
// Widths, register indexes, the folded pattern bundle and the case-fold helper.
// ----------------------------------------------------------------------------
package cssf_pkg;

   localparam int MAX_PATTERN_DEFAULT   = 16;
   localparam int POSITION_BITS_DEFAULT = 16;

   // The two pattern registers hold sixteen bytes whatever MAX_PATTERN is.
   localparam int PATTERN_SLOTS = 16;
   localparam int LEN_W         = 5;
   localparam int MATCH_START_W = 16;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] FOLD_MASK    = 8'h5f;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2
   } csr_index_type;

   // Pattern as the matcher wants it: lane i holds the folded pattern byte
   // that must sit i places before the newest text byte.
   typedef struct packed {
      logic [PATTERN_SLOTS-1:0][7:0] lane_byte;
      logic [PATTERN_SLOTS-1:0]      lane_used;
      logic [LEN_W-1:0]              length;
      logic                          active;
   } pattern_type;

   function automatic logic [7:0] fold_upper(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         r = b & FOLD_MASK;
      end
      return r;
   endfunction

endpackage

FILE: sv/cssf_csr.sv
// ----------------------------------------------------------------------------
// cssf_csr: pattern registers
// Holds the raw pattern registers and a registered, folded, length-aligned
// copy of the pattern for the matcher.
// ----------------------------------------------------------------------------
module cssf_csr #(
   parameter int MAX_PATTERN = cssf_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [cssf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cssf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output cssf_pkg::pattern_type                pattern
);
   import cssf_pkg::*;

   logic [CSR_DATA_W-1:0] pat_low_ff, pat_low_in;
   logic [CSR_DATA_W-1:0] pat_high_ff, pat_high_in;
   logic [LEN_W-1:0]      pat_len_ff, pat_len_in;
   pattern_type           aligned_ff, aligned_in;

   logic [PATTERN_SLOTS-1:0][7:0] raw_bytes;
   logic [LEN_W-1:0]              len_clamped;

   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      pat_len_in  = pat_len_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_PATTERN_LOW:    pat_low_in  = csr_wdata;
            CSR_PATTERN_HIGH:   pat_high_in = csr_wdata;
            CSR_PATTERN_LENGTH: pat_len_in  = csr_wdata[LEN_W-1:0];
            default:            ;
         endcase
      end
   end

   assign raw_bytes   = {pat_high_ff, pat_low_ff};
   assign len_clamped = (pat_len_ff > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_ff;

   always_comb begin
      logic [LEN_W-1:0] idx;
      aligned_in        = '0;
      aligned_in.length = len_clamped;
      aligned_in.active = (len_clamped != '0);
      for (int i = 0; i < PATTERN_SLOTS; i++) begin
         idx = len_clamped - LEN_W'(i) - LEN_W'(1);
         if (LEN_W'(i) < len_clamped) begin
            aligned_in.lane_used[i] = 1'b1;
            aligned_in.lane_byte[i] = fold_upper(raw_bytes[idx[LEN_W-2:0]]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
         aligned_ff  <= '0;
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         pat_len_ff  <= pat_len_in;
         aligned_ff  <= aligned_in;
      end
   end

   assign pattern = aligned_ff;

endmodule

FILE: sv/cssf_match.sv
// ----------------------------------------------------------------------------
// cssf_match: window compare and per-string state
// Keeps the recent folded bytes, the byte count and the first match, and
// works out the result for the final beat of a string.
// ----------------------------------------------------------------------------
module cssf_match #(
   parameter int MAX_PATTERN   = cssf_pkg::MAX_PATTERN_DEFAULT,
   parameter int POSITION_BITS = cssf_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic [7:0]                           text_byte,
   input  logic                                 last_byte,
   input  cssf_pkg::pattern_type                pattern,
   output logic                                 res_found,
   output logic [cssf_pkg::MATCH_START_W-1:0]   res_start
);
   import cssf_pkg::*;

   localparam int CNT_W = POSITION_BITS + 1;
   localparam int HIST  = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
   localparam logic [CNT_W-1:0] POS_MAX   = {1'b0, {POSITION_BITS{1'b1}}};
   localparam logic [CNT_W-1:0] COUNT_SAT = POS_MAX + CNT_W'(MAX_PATTERN);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic [POSITION_BITS-1:0] first_ff, first_in;
   logic [HIST-1:0][7:0]     recent_ff, recent_in;

   logic [7:0]                       cur;
   logic [MAX_PATTERN-1:0][7:0]      window;
   logic [MAX_PATTERN-1:0]           lane_ok;
   logic [CNT_W-1:0]                 cnt_next;
   logic [CNT_W-1:0]                 start;
   logic                             hit;
   logic [POSITION_BITS-1:0]         first_next;
   logic [POSITION_BITS+MATCH_START_W-1:0] first_ext;

   assign cur = fold_upper(text_byte);

   always_comb begin
      window[0] = cur;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         window[i] = recent_ff[i-1];
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
         lane_ok[i] = !pattern.lane_used[i] || (window[i] == pattern.lane_byte[i]);
      end
   end

   assign cnt_next = (count_ff < COUNT_SAT) ? count_ff + CNT_W'(1) : count_ff;
   assign start    = cnt_next - CNT_W'(pattern.length) + CNT_W'(1);

   // A start beyond the position range sets the top bit of start.
   assign hit = pattern.active && (first_ff == '0) && (cnt_next >= CNT_W'(pattern.length))
                && (&lane_ok) && !start[POSITION_BITS];

   assign first_next = hit ? start[POSITION_BITS-1:0] : first_ff;
   assign first_ext  = {{MATCH_START_W{1'b0}}, first_next};
   assign res_found  = (first_next != '0);
   assign res_start  = first_ext[MATCH_START_W-1:0];

   always_comb begin
      recent_in[0] = cur;
      for (int i = 1; i < HIST; i++) begin
         recent_in[i] = recent_ff[i-1];
      end
   end

   assign count_in = last_byte ? '0 : cnt_next;
   assign first_in = last_byte ? '0 : first_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         first_ff <= '0;
      end else if (step) begin
         count_ff <= count_in;
         first_ff <= first_in;
      end
   end

   // Window bytes need no clearing: a compare only looks at lanes the
   // byte count shows to belong to the current string.
   always_ff @(posedge clock) begin
      if (step) begin
         recent_ff <= recent_in;
      end
   end

endmodule

FILE: sv/caseless_substring_finder.sv
// ----------------------------------------------------------------------------
// caseless_substring_finder: case-insensitive substring search
// Streams a string one byte per beat and reports the start of the first
// occurrence of a configured pattern of up to sixteen bytes.
// ----------------------------------------------------------------------------
//
//   Port group   Direction   Handshake        Carries
//   req_*        in          valid / stall    one text byte, last-byte mark
//   rsp_*        out         valid / stall    found flag, 1-based match start
//   csr_*        in          write enable     pattern bytes and length
//
// One beat is taken every clock cycle unless req_stall is raised. A final
// beat moves from the input register to the output register, where its
// result is held until taken. The rate is set by the window compare and
// state update that sit between the input and output registers.
// Reset is synchronous and clears the pattern, the string state and both
// valid registers. A stalled result holds back only a following final beat;
// beats in the middle of a string keep flowing while the result waits.
//
// The block keeps the most recent MAX_PATTERN-1 text bytes, folded so that
// a to z compare equal to A to Z. On every beat the new byte and this
// window are compared in parallel against the folded pattern, which the
// register block keeps aligned to the pattern length so that lane i always
// faces the byte i places back. The first hit records its start position;
// a start above the position range is ignored. The final beat of a string
// delivers the result and clears the per-string state. An empty pattern
// never matches.
// ----------------------------------------------------------------------------
module caseless_substring_finder #(
   parameter int MAX_PATTERN   = cssf_pkg::MAX_PATTERN_DEFAULT,
   parameter int POSITION_BITS = cssf_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_text_byte,
   input  logic                                 req_last_byte,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_found,
   output logic [cssf_pkg::MATCH_START_W-1:0]   rsp_match_start,

   input  logic                                 csr_wen,
   input  logic [cssf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cssf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import cssf_pkg::*;

   // Input register: one beat waiting for the compare stage.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Output register: one finished result.
   logic                     out_valid_ff, out_valid_in;
   logic                     out_found_ff;
   logic [MATCH_START_W-1:0] out_start_ff;

   logic                     req_accept;
   logic                     advance;
   logic                     step;
   logic                     res_found;
   logic [MATCH_START_W-1:0] res_start;
   pattern_type              pattern;

   // A beat in the input register may move on unless it is a final beat and
   // the output register is full and not being emptied in this cycle.
   assign advance    = !in_last_ff || !out_valid_ff || !rsp_stall;
   assign step       = in_valid_ff && advance;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = (step && in_last_ff) || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_text_byte;
         in_last_ff <= req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         out_found_ff <= res_found;
         out_start_ff <= res_start;
      end
   end

   cssf_csr #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pattern   (pattern)
   );

   cssf_match #(
      .MAX_PATTERN   (MAX_PATTERN),
      .POSITION_BITS (POSITION_BITS)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .text_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .pattern   (pattern),
      .res_found (res_found),
      .res_start (res_start)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_found       = out_found_ff;
   assign rsp_match_start = out_start_ff;

endmodule

FILE: sv/cssf_checker.sv
// ----------------------------------------------------------------------------
// cssf_checker: port-level checks for the caseless substring finder
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module cssf_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 req_last_byte,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_found,
   input logic [cssf_pkg::MATCH_START_W-1:0]   rsp_match_start
);

   // A fresh result follows an accepted final request beat.
   a_result_needs_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_byte, 2))
      else $error("result appeared without a final request beat");

   // The found flag and the start position agree.
   a_found_matches_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == (rsp_match_start != '0)))
      else $error("found flag and match start disagree");

   // Requests are held back only while a result waits on a stalled consumer.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled with the result path free");

   // A stalled result beat stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_found) && $stable(rsp_match_start)))
      else $error("stalled result beat changed");

endmodule

bind caseless_substring_finder cssf_checker u_cssf_checker (.*);

FILE: verif/caseless_substring_finder_tb.sv
// ----------------------------------------------------------------------------
// caseless_substring_finder_tb: self-checking bench for the caseless finder
// Text beats are queued by the stimulus sequence, sent by a bursty driver and
// predicted on acceptance; a stalling monitor checks each result beat against
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module caseless_substring_finder_tb;
   import cssf_pkg::*;

   localparam int CLOCK_HALF     = 10;
   localparam int MAX_WINDOW     = MAX_PATTERN_DEFAULT;
   localparam int POS_LIMIT      = (1 << POSITION_BITS_DEFAULT) - 1;
   // The position count stops here; any start computed from it is still out
   // of range, so saturation never changes what is reported.
   localparam logic [16:0] COUNT_LIMIT = 17'(POS_LIMIT + MAX_WINDOW);
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_BEATS   = 450;
   // The bit that separates a lower-case letter from its upper-case form.
   localparam logic [7:0] CASE_BIT = 8'h20;
   // The timeout leaves a wide margin over what a full run needs.
   localparam longint TIMEOUT_TICKS = 64'd200_000 * 2 * CLOCK_HALF;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } text_beat_type;

   typedef struct packed {
      logic                     found;
      logic [MATCH_START_W-1:0] match_start;
   } finder_result_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_EVERY_THIRD,
      STALL_RANDOM,
      STALL_LONG
   } stall_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid     = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_text_byte = '0;
   logic                     req_last_byte = 1'b0;

   logic                     rsp_valid;
   logic                     rsp_stall     = 1'b0;
   logic                     rsp_found;
   logic [MATCH_START_W-1:0] rsp_match_start;

   logic                     csr_wen       = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index     = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata     = '0;

   caseless_substring_finder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_match_start (rsp_match_start),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Beats waiting to be sent, and results predicted but not yet seen.
   text_beat_type     pending_beats [$];
   finder_result_type expected_results [$];
   int                beats_in_flight = 0;
   int                failures = 0;

   // The bench's own copy of the pattern registers and the per-string state.
   logic [63:0]              pattern_low_copy = '0;
   logic [63:0]              pattern_high_copy = '0;
   logic [LEN_W-1:0]         pattern_length_copy = '0;
   logic [7:0]               recent_text [0:MAX_WINDOW-2];
   logic [16:0]              string_count = '0;
   logic [MATCH_START_W-1:0] earliest_start = '0;

   // Pattern as the stimulus sees it, used to plant occurrences in the text.
   logic [127:0] stim_pattern = '0;
   int           stim_span = 0;

   // Sender burst state and receiver stall state.
   int              burst_left = 0;
   int              idle_gap = 0;
   int              stall_tick = 0;
   stall_style_type stall_style = STALL_NONE;

   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_TICKS);
      $display("Test completed with failures");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Only a to z are folded; the neighbours of that range pass unchanged.
   function automatic logic [7:0] fold_case(input logic [7:0] b);
      if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
         return b & FOLD_MASK;
      end
      return b;
   endfunction

   function automatic logic [7:0] folded_pattern_byte(input int idx);
      logic [63:0] word;
      word = (idx < 8) ? pattern_low_copy : pattern_high_copy;
      return fold_case(word[(idx % 8) * 8 +: 8]);
   endfunction

   function automatic void clear_string_state();
      foreach (recent_text[k]) begin
         recent_text[k] = '0;
      end
      string_count   = '0;
      earliest_start = '0;
   endfunction

   // Advances the string state by one accepted text beat; a final beat
   // queues the result that the block must give for the whole string.
   function automatic void predict_beat(input logic [7:0] text_byte,
                                        input logic last_byte);
      logic [7:0]        folded;
      int                span;
      logic              matched;
      logic [16:0]       start;
      finder_result_type outcome;
      folded = fold_case(text_byte);
      span   = (pattern_length_copy > MAX_WINDOW) ? MAX_WINDOW : pattern_length_copy;
      if (string_count < COUNT_LIMIT) begin
         string_count++;
      end
      // Only the first occurrence counts, and none can end before the string
      // holds at least as many bytes as the pattern.
      if (span != 0 && earliest_start == 0 && string_count >= span) begin
         matched = (folded == folded_pattern_byte(span - 1));
         for (int k = 0; k + 1 < span; k++) begin
            if (recent_text[k] != folded_pattern_byte(span - 2 - k)) begin
               matched = 1'b0;
            end
         end
         if (matched) begin
            start = string_count - 17'(span) + 17'd1;
            if (start <= POS_LIMIT) begin
               earliest_start = start[MATCH_START_W-1:0];
            end
         end
      end
      for (int k = MAX_WINDOW - 2; k > 0; k--) begin
         recent_text[k] = recent_text[k-1];
      end
      recent_text[0] = folded;
      if (last_byte) begin
         outcome.found       = (earliest_start != 0);
         outcome.match_start = earliest_start;
         expected_results.push_back(outcome);
         clear_string_state();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driver: sends queued text beats in bursts of random length with random
   // gaps between them. A beat that is stalled is held unchanged.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : text_sender
      text_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_beat(req_text_byte, req_last_byte);
            beats_in_flight--;
         end
         if (!req_valid || !req_stall) begin
            if (idle_gap != 0 || pending_beats.size() == 0) begin
               req_valid <= 1'b0;
               if (idle_gap != 0) begin
                  idle_gap--;
               end
            end else begin
               beat = pending_beats.pop_front();
               req_valid     <= 1'b1;
               req_text_byte <= beat.text_byte;
               req_last_byte <= beat.last_byte;
               if (burst_left <= 1) begin
                  // A quarter of the bursts run straight into the next one,
                  // which gives long stretches at the full rate.
                  burst_left = $urandom_range(1, 24);
                  idle_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each accepted result beat and stalls the result channel
   // in a style that is picked again at random at regular intervals.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_checker
      finder_result_type wanted;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result beat with nothing expected: found %0d, match_start %0d",
                      rsp_found, rsp_match_start);
               failures++;
            end else begin
               wanted = expected_results.pop_front();
               if (rsp_found !== wanted.found) begin
                  $error("found: expected %0d, got %0d", wanted.found, rsp_found);
                  failures++;
               end
               if (rsp_match_start !== wanted.match_start) begin
                  $error("match_start: expected %0d, got %0d",
                         wanted.match_start, rsp_match_start);
                  failures++;
               end
            end
         end
         stall_tick++;
         if (stall_tick % 64 == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
         end
         case (stall_style)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_EVERY_THIRD: begin
               rsp_stall <= (stall_tick % 3 == 0);
            end
            STALL_RANDOM: begin
               rsp_stall <= ($urandom_range(0, 1) == 1);
            end
            default: begin
               // Stalls a quarter of the time, in unbroken runs.
               rsp_stall <= ((stall_tick / 8) % 4 == 3);
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic void push_beat(input logic [7:0] text_byte, input logic last_byte);
      text_beat_type beat;
      beat.text_byte = text_byte;
      beat.last_byte = last_byte;
      pending_beats.push_back(beat);
      beats_in_flight++;
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_beat(s[i], i == s.len() - 1);
      end
   endfunction

   // Letters get a random case; every other byte is left as it is.
   function automatic logic [7:0] random_case(input logic [7:0] b);
      logic [7:0] lower;
      lower = b | CASE_BIT;
      if (lower >= CHAR_LOWER_A && lower <= CHAR_LOWER_Z && $urandom_range(0, 1) == 1) begin
         return b ^ CASE_BIT;
      end
      return b;
   endfunction

   function automatic logic [7:0] random_letter(input int spread);
      return random_case(CHAR_LOWER_A + 8'($urandom_range(0, spread - 1)));
   endfunction

   // Waits until every queued beat has gone and every result has come, then
   // lets the block settle so that it can finish any work in its pipeline.
   task automatic wait_for_idle();
      while (beats_in_flight != 0 || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PATTERN_LOW: begin
            pattern_low_copy = value;
         end
         CSR_PATTERN_HIGH: begin
            pattern_high_copy = value;
         end
         CSR_PATTERN_LENGTH: begin
            pattern_length_copy = value[LEN_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   // Loads a new pattern once the block has gone idle. Only the low five
   // bits of the length word are meant to matter.
   task automatic configure(input logic [127:0] pattern, input logic [63:0] length_word);
      wait_for_idle();
      write_register(CSR_PATTERN_LOW, pattern[63:0]);
      write_register(CSR_PATTERN_HIGH, pattern[127:64]);
      write_register(CSR_PATTERN_LENGTH, length_word);
      @(posedge clock);
      csr_wen <= 1'b0;
      stim_pattern = pattern;
      stim_span    = (length_word[LEN_W-1:0] > MAX_WINDOW) ? MAX_WINDOW
                                                           : length_word[LEN_W-1:0];
   endtask

   // Queues one string and returns its length. Most strings are built from
   // the pattern's own bytes with one or two planted copies, some of them
   // spoilt by a flipped bit; the rest are raw noise.
   function automatic int queue_random_text();
      logic [7:0] text_buf [$];
      int         n;
      int         pos;
      int         pick;
      logic [7:0] b;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 14);
      if ($urandom_range(0, 3) == 0) begin
         for (int i = 0; i < n; i++) begin
            text_buf.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               b = 8'($urandom_range(0, 255));
            end else if (stim_span != 0) begin
               pick = $urandom_range(0, stim_span - 1);
               b    = random_case(stim_pattern[pick * 8 +: 8]);
            end else begin
               b = random_letter(3);
            end
            text_buf.push_back(b);
         end
         if (stim_span != 0 && stim_span <= n) begin
            repeat ($urandom_range(1, 2)) begin
               pos = $urandom_range(0, n - stim_span);
               for (int k = 0; k < stim_span; k++) begin
                  text_buf[pos + k] = random_case(stim_pattern[k * 8 +: 8]);
               end
            end
            if ($urandom_range(0, 3) == 0) begin
               pos = $urandom_range(0, n - 1);
               text_buf[pos] = text_buf[pos] ^ (8'd1 << $urandom_range(0, 7));
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         push_beat(text_buf[i], i == n - 1);
      end
      return n;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int           random_beats;
      int           phase_count;
      int           span_choice;
      int           byte_style;
      logic [127:0] pattern;
      logic [63:0]  length_word;
      int           opening_lengths [6];

      opening_lengths = '{16, 31, 1, 0, 17, 5};
      clear_string_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // An empty pattern straight after reset can never be found.
      push_beat(8'hff, 1'b0);
      push_beat(CHAR_LOWER_Z, 1'b1);

      // Mixed-case pattern: found one place in, and a string shorter than
      // the pattern that happens to be its prefix.
      configure(128'h63_42_61, 64'd3);
      push_text("xAbC");
      push_text("ab");

      // The bytes just outside a to z must not fold onto their upper-case
      // neighbours, so only the literal pair matches.
      configure(128'h7b_60, 64'd2);
      push_text("@[`{");

      // A zero pattern byte matches only a zero text byte.
      configure(128'h41_00, 64'd2);
      push_beat(8'h41, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'h61, 1'b1);

      // All-ones pattern with an oversized length, which acts as sixteen.
      configure({128{1'b1}}, 64'd31);
      for (int i = 0; i < 16; i++) begin
         push_beat(8'hff, i == 15);
      end

      // Random phases: a fresh pattern and length each time, with the
      // extremes of the length taken first.
      random_beats = 0;
      phase_count  = 0;
      while (random_beats < RANDOM_BEATS) begin
         if (phase_count < 6) begin
            span_choice = opening_lengths[phase_count];
         end else begin
            case ($urandom_range(0, 6))
               0: span_choice = $urandom_range(0, 31);
               1: span_choice = $urandom_range(7, 16);
               default: span_choice = $urandom_range(1, 6);
            endcase
         end
         byte_style = $urandom_range(0, 2);
         for (int k = 0; k < 16; k++) begin
            pattern[k * 8 +: 8] = (byte_style == 2) ? 8'($urandom_range(0, 255))
                                                    : random_letter(3);
         end
         length_word = {$urandom, $urandom};
         length_word[LEN_W-1:0] = LEN_W'(span_choice);
         configure(pattern, length_word);
         repeat ($urandom_range(3, 8)) begin
            random_beats += queue_random_text();
         end
         phase_count++;
      end

      // Letters mixed with punctuation, found at the very start of a string.
      configure(128'h23_21_7a_71, 64'd4);
      push_text("qZ!#");

      wait_for_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
